/* sv/clt_pkg.sv */
// Package: widths, command and status codes, controller types for the cursor line table.
`default_nettype none
package clt_pkg;

  localparam int LINE_W            = 11;
  localparam int DATA_W            = 64;
  localparam int CMD_W             = 3;
  localparam int STAT_W            = 2;
  localparam int DEPTH_DEF         = 1024;
  localparam int ENTRY_WIDTH_DEF   = 64;

  localparam logic [CMD_W-1:0] CMD_BACK   = 3'd0;
  localparam logic [CMD_W-1:0] CMD_MOVE   = 3'd1;
  localparam logic [CMD_W-1:0] CMD_DELETE = 3'd2;
  localparam logic [CMD_W-1:0] CMD_INSERT = 3'd3;
  localparam logic [CMD_W-1:0] CMD_APPEND = 3'd4;

  localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
  localparam logic [STAT_W-1:0] ST_RANGE  = 2'd1;
  localparam logic [STAT_W-1:0] ST_DELETE = 2'd2;
  localparam logic [STAT_W-1:0] ST_FULL   = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_SHIFT,
    S_DRAIN,
    S_PLACE,
    S_RESP
  } state_t;

  typedef struct packed {
    logic capture;
    logic decode;
    logic shift;
    logic drain;
    logic place;
    logic respond;
  } ctrl_cmd_t;

  typedef struct packed {
    logic             ok;
    logic [CMD_W-1:0] op;
    logic             more;
    logic             out_free;
  } dp_stat_t;

endpackage
`default_nettype wire

/* sv/clt_ctrl.sv */
// Controller state machine sequencing decode, entry shifting, placement and result beat.
`default_nettype none
module clt_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire clt_pkg::dp_stat_t  stat,
  output clt_pkg::ctrl_cmd_t      cmd
);

  clt_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= clt_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      clt_pkg::S_IDLE: begin
        if (in_valid) state_nxt = clt_pkg::S_DECODE;
      end
      clt_pkg::S_DECODE: begin
        if (stat.ok && (stat.op == clt_pkg::CMD_DELETE || stat.op == clt_pkg::CMD_INSERT ||
                        stat.op == clt_pkg::CMD_APPEND)) begin
          state_nxt = clt_pkg::S_SHIFT;
        end else begin
          state_nxt = clt_pkg::S_RESP;
        end
      end
      clt_pkg::S_SHIFT: begin
        if (!stat.more) state_nxt = clt_pkg::S_DRAIN;
      end
      clt_pkg::S_DRAIN: begin
        if (stat.op == clt_pkg::CMD_DELETE) begin
          state_nxt = clt_pkg::S_RESP;
        end else begin
          state_nxt = clt_pkg::S_PLACE;
        end
      end
      clt_pkg::S_PLACE: begin
        state_nxt = clt_pkg::S_RESP;
      end
      clt_pkg::S_RESP: begin
        if (stat.out_free) state_nxt = clt_pkg::S_IDLE;
      end
      default: begin
        state_nxt = clt_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd         = '0;
    in_stall    = 1'b1;
    case (state_r)
      clt_pkg::S_IDLE: begin
        in_stall    = 1'b0;
        cmd.capture = in_valid;
      end
      clt_pkg::S_DECODE: cmd.decode = 1'b1;
      clt_pkg::S_SHIFT:  cmd.shift  = 1'b1;
      clt_pkg::S_DRAIN:  cmd.drain  = 1'b1;
      clt_pkg::S_PLACE:  cmd.place  = 1'b1;
      clt_pkg::S_RESP:   cmd.respond = stat.out_free;
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule
`default_nettype wire

/* sv/clt_dpath.sv */
// Datapath: entry memory, cursor and count, shift counters, checks and output register.
`default_nettype none
module clt_dpath #(
  parameter int DEPTH       = clt_pkg::DEPTH_DEF,
  parameter int ENTRY_WIDTH = clt_pkg::ENTRY_WIDTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire clt_pkg::ctrl_cmd_t            cmd,
  output clt_pkg::dp_stat_t                  stat,
  input  wire logic [clt_pkg::CMD_W-1:0]     in_command,
  input  wire logic [clt_pkg::LINE_W-1:0]    in_line_number,
  input  wire logic [clt_pkg::LINE_W-1:0]    in_range_end,
  input  wire logic [clt_pkg::DATA_W-1:0]    in_entry_data,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [clt_pkg::STAT_W-1:0]         out_status,
  output logic [clt_pkg::DATA_W-1:0]         out_read_data,
  output logic [clt_pkg::LINE_W-1:0]         out_cursor_now,
  output logic [clt_pkg::LINE_W-1:0]         out_count_now
);

  localparam int PW = $clog2(DEPTH + 1);
  localparam int AW = $clog2(DEPTH);
  localparam int CW = ((PW > clt_pkg::LINE_W) ? PW : clt_pkg::LINE_W) + 1;
  localparam logic [CW-1:0] DEPTH_X = CW'(DEPTH);
  localparam logic [CW-1:0] ONE_X   = CW'(1);

  logic [ENTRY_WIDTH-1:0] mem [DEPTH];

  logic [PW-1:0]              cursor_r, count_r;
  logic [clt_pkg::CMD_W-1:0]  op_r;
  logic [CW-1:0]              first_r, last_r, pos_r, src_r, dst_r;
  logic [ENTRY_WIDTH-1:0]     word_r, rd_data_r;
  logic                       pend_r;
  logic [AW-1:0]              pend_addr_r;
  logic [clt_pkg::STAT_W-1:0] status_r;

  logic                       out_valid_r;
  logic [clt_pkg::STAT_W-1:0] out_status_r;
  logic [clt_pkg::DATA_W-1:0] out_read_data_r;
  logic [clt_pkg::LINE_W-1:0] out_cursor_r, out_count_r;

  logic [CW-1:0]              cur_x, cnt_x, pos_calc, rd_pos, rd_pos_m1, cnt_del, cur_ext;
  logic [clt_pkg::STAT_W-1:0] code;
  logic                       ok, more, rd_en, wr_en, is_del;
  logic [AW-1:0]              wr_addr;
  logic [ENTRY_WIDTH-1:0]     wr_data;

  assign cur_x  = CW'(cursor_r);
  assign cnt_x  = CW'(count_r);
  assign is_del = (op_r == clt_pkg::CMD_DELETE);

  always_comb begin
    pos_calc = cur_x;
    if (op_r == clt_pkg::CMD_INSERT) begin
      pos_calc = (cur_x >= ONE_X) ? cur_x - ONE_X : '0;
    end
  end

  always_comb begin
    code = clt_pkg::ST_OK;
    case (op_r)
      clt_pkg::CMD_BACK: begin
        if (cur_x <= ONE_X) code = clt_pkg::ST_RANGE;
      end
      clt_pkg::CMD_MOVE: begin
        if (first_r == '0 || first_r > cnt_x || first_r > DEPTH_X) code = clt_pkg::ST_RANGE;
      end
      clt_pkg::CMD_DELETE: begin
        if (first_r == '0 || last_r > cnt_x || first_r > last_r) code = clt_pkg::ST_DELETE;
      end
      clt_pkg::CMD_INSERT, clt_pkg::CMD_APPEND: begin
        if (cnt_x >= DEPTH_X || pos_calc >= DEPTH_X) code = clt_pkg::ST_FULL;
      end
      default: begin
        code = clt_pkg::ST_OK;
      end
    endcase
  end

  assign ok   = (code == clt_pkg::ST_OK);
  assign more = is_del ? (src_r <= cnt_x) : (src_r > pos_r);

  assign rd_en     = (cmd.decode && ok && op_r == clt_pkg::CMD_MOVE) || (cmd.shift && more);
  assign rd_pos    = cmd.decode ? first_r : src_r;
  assign rd_pos_m1 = rd_pos - ONE_X;

  assign wr_en   = pend_r || cmd.place;
  assign wr_addr = pend_r ? pend_addr_r : pos_r[AW-1:0];
  assign wr_data = pend_r ? rd_data_r : word_r;

  assign cnt_del = cnt_x - (last_r - first_r + ONE_X);
  assign cur_ext = pos_r + ONE_X;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_data_r <= mem[rd_pos_m1[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cursor_r    <= '0;
      count_r     <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      pend_r <= cmd.shift && more;
      if (cmd.decode && ok && op_r == clt_pkg::CMD_BACK) cursor_r <= cursor_r - PW'(1);
      if (cmd.decode && ok && op_r == clt_pkg::CMD_MOVE) cursor_r <= first_r[PW-1:0];
      if (cmd.drain && is_del) count_r <= cnt_del[PW-1:0];
      if (cmd.place) begin
        cursor_r <= cur_ext[PW-1:0];
        count_r  <= count_r + PW'(1);
      end
      if (cmd.respond) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r    <= in_command;
      first_r <= CW'(in_line_number);
      last_r  <= CW'(in_range_end);
      word_r  <= in_entry_data[ENTRY_WIDTH-1:0];
    end
    if (cmd.decode) begin
      status_r <= code;
      pos_r    <= pos_calc;
      src_r    <= is_del ? last_r + ONE_X : cnt_x;
      dst_r    <= first_r;
    end
    if (cmd.shift && more) begin
      src_r       <= is_del ? src_r + ONE_X : src_r - ONE_X;
      dst_r       <= dst_r + ONE_X;
      pend_addr_r <= is_del ? dst_r[AW-1:0] - AW'(1) : src_r[AW-1:0];
    end
    if (cmd.respond) begin
      out_status_r    <= status_r;
      out_read_data_r <= (op_r == clt_pkg::CMD_MOVE && status_r == clt_pkg::ST_OK) ?
                         clt_pkg::DATA_W'(rd_data_r) : '0;
      out_cursor_r    <= cur_x[clt_pkg::LINE_W-1:0];
      out_count_r     <= cnt_x[clt_pkg::LINE_W-1:0];
    end
  end

  assign stat.ok       = ok;
  assign stat.op       = op_r;
  assign stat.more     = more;
  assign stat.out_free = !out_valid_r || !out_stall;

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_read_data  = out_read_data_r;
  assign out_cursor_now = out_cursor_r;
  assign out_count_now  = out_count_r;

endmodule
`default_nettype wire

/* sv/cursor_line_table_top.sv */
// Sequence: a beat is decoded; step back, move, failed and unused ops then give the result beat.
// Delete shifts entries above the range down and drains; insert/append shift entries up, drain
// and place the new entry, copying one entry per cycle via the memory's one read and write port.
// A new command is accepted only after the last result beat is issued; output stalls delay that.
// Reset: cursor and count clear to zero; the entry memory is not cleared, entries read back
// only after being written.
`default_nettype none
module cursor_line_table_top #(
  parameter int DEPTH       = clt_pkg::DEPTH_DEF,
  parameter int ENTRY_WIDTH = clt_pkg::ENTRY_WIDTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [clt_pkg::CMD_W-1:0]     in_command,
  input  wire logic [clt_pkg::LINE_W-1:0]    in_line_number,
  input  wire logic [clt_pkg::LINE_W-1:0]    in_range_end,
  input  wire logic [clt_pkg::DATA_W-1:0]    in_entry_data,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [clt_pkg::STAT_W-1:0]         out_status,
  output logic [clt_pkg::DATA_W-1:0]         out_read_data,
  output logic [clt_pkg::LINE_W-1:0]         out_cursor_now,
  output logic [clt_pkg::LINE_W-1:0]         out_count_now
);

  clt_pkg::ctrl_cmd_t cmd;
  clt_pkg::dp_stat_t  stat;

  clt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  clt_dpath #(
    .DEPTH       (DEPTH),
    .ENTRY_WIDTH (ENTRY_WIDTH)
  ) u_dpath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .stat           (stat),
    .in_command     (in_command),
    .in_line_number (in_line_number),
    .in_range_end   (in_range_end),
    .in_entry_data  (in_entry_data),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_status     (out_status),
    .out_read_data  (out_read_data),
    .out_cursor_now (out_cursor_now),
    .out_count_now  (out_count_now)
  );

  a_capture_then_decode: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.capture |=> cmd.decode)
    else $error("accepted beat not decoded");

  a_respond_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.respond |-> (!out_valid || !out_stall))
    else $error("result beat overwrites a stalled result");

  a_result_from_respond: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(cmd.respond))
    else $error("result beat without respond");

  a_one_phase: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.capture, cmd.decode, cmd.shift, cmd.drain, cmd.place, cmd.respond}))
    else $error("controller issued more than one command");

endmodule
`default_nettype wire
